// ===== src/blrc_pkg.sv =====
// ----------------------------------------------------------------------------
// blrc_pkg: shared types and constants of the byte-budget LRU table
// Sizes, operation and status codes, the stored entry layout and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package blrc_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int TAG_BITS    = 64;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int SIZE_W      = 25;
	localparam int TIME_W      = 64;
	localparam int TTL_W       = 32;
	localparam int STAMP_W     = 64;
	localparam int CTR_W       = 48;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 32;
	localparam logic [TIME_W-1:0] SWEEP_GAP_MS = TIME_W'(2000);

	// Operation codes.
	localparam logic [1:0] FN_GET      = 2'd0;
	localparam logic [1:0] FN_PUT      = 2'd1;
	localparam logic [1:0] FN_CONTAINS = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TTL      = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		ST_HIT       = 2'd0,
		ST_MISS      = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_PRESENT   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SEL_ZERO  = 2'd0,
		SEL_MATCH = 2'd1,
		SEL_FREE  = 2'd2
	} slot_sel_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_TTL_CHK, S_TTL_SCAN, S_BUD_CHK, S_BUD_SCAN,
		S_FULL_CHK, S_INSERT, S_HIT_WR, S_RESP
	} state_t;

	// One stored table entry. The stamp orders entries by recency.
	typedef struct packed {
		logic [TAG_BITS-1:0] tag;
		logic [SIZE_W-1:0]   size;
		logic [TIME_W-1:0]   last;
		logic [STAMP_W-1:0]  stamp;
	} entry_t;

	typedef struct packed {
		logic      latch;
		logic      scan_start;
		logic      evict;
		logic      insert;
		logic      hit_wr;
		logic      sweep;
		logic      res_load;
		status_t   res_status;
		slot_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic       scan_done;
		logic       match_found;
		logic       tail_found;
		logic       expired;
		logic       over;
		logic       full;
		logic       too_large;
		logic       sweep_due;
		logic       out_free;
		logic [1:0] func;
	} stat_t;

endpackage

// ===== src/blrc_ram.sv =====
// ----------------------------------------------------------------------------
// blrc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module blrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/blrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// blrc_ctrl: operation sequencer of the byte-budget LRU table
// Steps each word through lookup and, as its operation needs, expiry sweep,
// budget eviction, insert or hit refresh and response, driving the datapath by commands.
// ----------------------------------------------------------------------------
module blrc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  blrc_pkg::stat_t  st,
	output blrc_pkg::cmd_t   cmd
);
	import blrc_pkg::*;

	state_t    state_q, state_nxt;
	status_t   sts_q, sts_nxt;
	slot_sel_t sel_q, sel_nxt;

	// State and pending response registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sts_q   <= ST_MISS;
			sel_q   <= SEL_ZERO;
		end else begin
			state_q <= state_nxt;
			sts_q   <= sts_nxt;
			sel_q   <= sel_nxt;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		sts_nxt   = sts_q;
		sel_nxt   = sel_q;
		cmd       = '0;
		cmd.res_status = sts_q;
		cmd.res_sel    = sel_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch      = 1'b1;
					cmd.scan_start = 1'b1;
					state_nxt      = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.scan_done) state_nxt = S_DECIDE;
			end
			S_DECIDE: begin
				state_nxt = S_RESP;
				sts_nxt   = ST_MISS;
				sel_nxt   = SEL_ZERO;
				case (st.func)
					FN_GET: begin
						if (st.match_found) state_nxt = S_HIT_WR;
					end
					FN_PUT: begin
						if (st.too_large) begin
							sts_nxt = ST_TOO_LARGE;
						end else if (st.match_found) begin
							sts_nxt = ST_PRESENT;
							sel_nxt = SEL_MATCH;
						end else if (st.sweep_due) begin
							cmd.sweep = 1'b1;
							state_nxt = S_TTL_CHK;
						end else begin
							state_nxt = S_BUD_CHK;
						end
					end
					FN_CONTAINS: begin
						if (st.match_found) begin
							sts_nxt = ST_HIT;
							sel_nxt = SEL_MATCH;
						end
					end
					default: begin
						sts_nxt = ST_MISS;
					end
				endcase
			end
			S_TTL_CHK: begin
				if (st.tail_found && st.expired) begin
					cmd.evict      = 1'b1;
					cmd.scan_start = 1'b1;
					state_nxt      = S_TTL_SCAN;
				end else begin
					state_nxt = S_BUD_CHK;
				end
			end
			S_TTL_SCAN: begin
				if (st.scan_done) state_nxt = S_TTL_CHK;
			end
			S_BUD_CHK: begin
				if (st.tail_found && st.over) begin
					cmd.evict      = 1'b1;
					cmd.scan_start = 1'b1;
					state_nxt      = S_BUD_SCAN;
				end else begin
					state_nxt = S_FULL_CHK;
				end
			end
			S_BUD_SCAN: begin
				if (st.scan_done) state_nxt = S_BUD_CHK;
			end
			S_FULL_CHK: begin
				if (st.tail_found && st.full) cmd.evict = 1'b1;
				state_nxt = S_INSERT;
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				sts_nxt    = ST_HIT;
				sel_nxt    = SEL_FREE;
				state_nxt  = S_RESP;
			end
			S_HIT_WR: begin
				cmd.hit_wr = 1'b1;
				sts_nxt    = ST_HIT;
				sel_nxt    = SEL_MATCH;
				state_nxt  = S_RESP;
			end
			S_RESP: begin
				if (st.out_free) begin
					cmd.res_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ===== src/blrc_dp.sv =====
// ----------------------------------------------------------------------------
// blrc_dp: datapath of the byte-budget LRU table
// Entry memory, valid bits, scan engine for lookup, free slot and tail,
// byte and entry accounting, counters and the output register.
// ----------------------------------------------------------------------------
module blrc_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  blrc_pkg::cmd_t                     cmd,
	output blrc_pkg::stat_t                    st,
	input  logic                               cfg_valid,
	input  logic [blrc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [blrc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [1:0]                         func,
	input  logic [63:0]                        key_tag,
	input  logic [blrc_pkg::SIZE_W-1:0]        payload_size,
	input  logic [blrc_pkg::TIME_W-1:0]        now_ms,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         status,
	output logic [blrc_pkg::IDX_W-1:0]         slot,
	output logic [blrc_pkg::CNT_W-1:0]         entry_count,
	output logic [blrc_pkg::SIZE_W-1:0]        resident_bytes,
	output logic [blrc_pkg::CTR_W-1:0]         hit_count,
	output logic [blrc_pkg::CTR_W-1:0]         store_count
);
	import blrc_pkg::*;

	// Configuration and latched input word.
	logic [SIZE_W-1:0]   cap_q;
	logic [TTL_W-1:0]    ttl_q;
	logic [1:0]          func_q;
	logic [TAG_BITS-1:0] key_q;
	logic [SIZE_W-1:0]   size_q;
	logic [TIME_W-1:0]   now_q;

	// Table state.
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]       count_q;
	logic [SIZE_W-1:0]      bytes_q;
	logic [TIME_W-1:0]      last_sweep_q;
	logic [CTR_W-1:0]       hits_q;
	logic [CTR_W-1:0]       stores_q;
	logic [STAMP_W-1:0]     stamp_q;

	// Scan engine.
	logic                   scan_act_q;
	logic [CNT_W-1:0]       rd_idx_q;
	logic                   cmp_vld_s1;
	logic [IDX_W-1:0]       cmp_idx_s1;
	entry_t                 rdata;
	logic                   match_found_q, free_found_q, tail_found_q;
	logic [IDX_W-1:0]       match_idx_q, free_idx_q, tail_idx_q;
	logic [SIZE_W-1:0]      match_size_q, tail_size_q;
	logic [TIME_W-1:0]      tail_last_q;
	logic [STAMP_W-1:0]     tail_stamp_q;
	logic                   scan_done;
	logic                   rd_more;

	// Memory write port.
	logic                   we;
	logic [IDX_W-1:0]       waddr;
	entry_t                 wdata;

	logic out_valid_q;

	assign rd_more   = scan_act_q && (rd_idx_q < CNT_W'(MAX_ENTRIES));
	assign scan_done = cmp_vld_s1 && (cmp_idx_s1 == IDX_W'(MAX_ENTRIES - 1));

	// Configuration registers; the user is to write them only while idle, the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= SIZE_W'(1048576);
			ttl_q <= TTL_W'(60000);
		end else if (cfg_valid) begin
			if (cfg_index == CFG_CAPACITY) cap_q <= cfg_data[SIZE_W-1:0];
			else if (cfg_index == CFG_TTL) ttl_q <= cfg_data[TTL_W-1:0];
		end
	end

	// Latch the accepted input word.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= func;
			key_q  <= key_tag[TAG_BITS-1:0];
			size_q <= payload_size;
			now_q  <= now_ms;
		end
	end

	// Scan address counter and compare stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_act_q <= 1'b0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			cmp_vld_s1 <= rd_more;
			cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
			if (cmd.scan_start) begin
				scan_act_q <= 1'b1;
				rd_idx_q   <= '0;
			end else if (rd_more) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end else begin
				scan_act_q <= 1'b0;
			end
		end
	end

	// Scan results: matching tag, lowest free slot and least-recent entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			tail_found_q  <= 1'b0;
		end else if (cmd.scan_start) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			tail_found_q  <= 1'b0;
		end else if (cmd.evict) begin
			tail_found_q <= 1'b0;
			if (!free_found_q || (tail_idx_q < free_idx_q)) begin
				free_found_q <= 1'b1;
			end
		end else if (cmp_vld_s1) begin
			if (valid_q[cmp_idx_s1]) begin
				if (!match_found_q && (rdata.tag == key_q)) match_found_q <= 1'b1;
				tail_found_q <= 1'b1;
			end else begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.evict) begin
			if (!free_found_q || (tail_idx_q < free_idx_q)) free_idx_q <= tail_idx_q;
		end else if (!cmd.scan_start && cmp_vld_s1) begin
			if (valid_q[cmp_idx_s1]) begin
				if (!match_found_q && (rdata.tag == key_q)) begin
					match_idx_q  <= cmp_idx_s1;
					match_size_q <= rdata.size;
				end
				if (!tail_found_q || (rdata.stamp < tail_stamp_q)) begin
					tail_idx_q   <= cmp_idx_s1;
					tail_size_q  <= rdata.size;
					tail_last_q  <= rdata.last;
					tail_stamp_q <= rdata.stamp;
				end
			end else if (!free_found_q) begin
				free_idx_q <= cmp_idx_s1;
			end
		end
	end

	// Entry memory writes on insert and on hit refresh.
	always_comb begin
		we          = cmd.insert || cmd.hit_wr;
		waddr       = cmd.insert ? free_idx_q : match_idx_q;
		wdata.tag   = key_q;
		wdata.size  = cmd.insert ? size_q : match_size_q;
		wdata.last  = now_q;
		wdata.stamp = stamp_q;
	end

	blrc_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	// Valid bits, occupancy, byte accounting and lifetime counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			count_q      <= '0;
			bytes_q      <= '0;
			last_sweep_q <= '0;
			hits_q       <= '0;
			stores_q     <= '0;
			stamp_q      <= '0;
		end else begin
			if (cmd.sweep) last_sweep_q <= now_q;
			if (cmd.evict) begin
				valid_q[tail_idx_q] <= 1'b0;
				count_q <= count_q - CNT_W'(1);
				bytes_q <= (tail_size_q <= bytes_q) ? (bytes_q - tail_size_q) : '0;
			end
			if (cmd.insert) begin
				valid_q[free_idx_q] <= 1'b1;
				count_q  <= count_q + CNT_W'(1);
				bytes_q  <= bytes_q + size_q;
				stores_q <= stores_q + CTR_W'(1);
				stamp_q  <= stamp_q + STAMP_W'(1);
			end
			if (cmd.hit_wr) begin
				hits_q  <= hits_q + CTR_W'(1);
				stamp_q <= stamp_q + STAMP_W'(1);
			end
		end
	end

	// Output register; a waiting word holds until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status         <= cmd.res_status;
			entry_count    <= count_q;
			resident_bytes <= bytes_q;
			hit_count      <= hits_q;
			store_count    <= stores_q;
			case (cmd.res_sel)
				SEL_MATCH: slot <= match_idx_q;
				SEL_FREE:  slot <= free_idx_q;
				default:   slot <= '0;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// Status toward the controller.
	always_comb begin
		st.scan_done   = scan_done;
		st.match_found = match_found_q;
		st.tail_found  = tail_found_q;
		st.expired     = (now_q - tail_last_q) > {{(TIME_W-TTL_W){1'b0}}, ttl_q};
		st.over        = ({1'b0, bytes_q} + {1'b0, size_q}) > {1'b0, cap_q};
		st.full        = (count_q == CNT_W'(MAX_ENTRIES));
		st.too_large   = (size_q > cap_q);
		st.sweep_due   = ((now_q - last_sweep_q) >= SWEEP_GAP_MS);
		st.out_free    = !out_valid_q || !out_stall;
		st.func        = func_q;
	end

	// The occupancy count tracks the valid bits.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(valid_q)))
		else $error("entry count disagrees with valid bits");

	// An insert always lands in a slot that is free.
	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> (free_found_q && !valid_q[free_idx_q]))
		else $error("insert without a free slot");

	// Eviction only removes a valid least-recent entry.
	a_evict_tail: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict |-> (tail_found_q && valid_q[tail_idx_q]))
		else $error("eviction without a valid tail");

	// A new result is never loaded over one still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.res_load)
		else $error("result overwritten while stalled");

endmodule

// ===== src/byte_budget_lru_cache_with_ttl.sv =====
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_with_ttl: size-weighted LRU table with expiry
// One shard of tagged entries with a byte budget and recency order.
// ----------------------------------------------------------------------------
// Usage: an input word (func, key_tag, payload_size, now_ms) is taken when
// in_valid is high and in_stall is low. Each word gives exactly one result
// word on the output channel, taken when out_valid is high and out_stall low.
// Configuration writes (cfg_index 0 capacity, 1 ttl) use cfg_valid/cfg_ready
// and are taken in every cycle; they should be issued while the table is idle.
// Flow: every operation first scans the entry memory, one entry per cycle
// through its read port. Contains, misses and rejected puts present their
// result after the scan, a get hit after a refresh write as well. A put that
// inserts takes longer than a miss, longer still when an expiry sweep is due,
// plus one rescan of the memory per expired or budget eviction, so its time
// grows with the number of entries it evicts. One word is in work at a time;
// the next word is taken the cycle after a result is handed to the output
// register, even while that result waits behind out_stall.
// Reset empties the table at once (valid bits are flip-flops); no clearing
// pass is needed, and the first word may follow right after reset.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_with_ttl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [blrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [blrc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      func,
	input  logic [63:0]                     key_tag,
	input  logic [blrc_pkg::SIZE_W-1:0]     payload_size,
	input  logic [blrc_pkg::TIME_W-1:0]     now_ms,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic [blrc_pkg::IDX_W-1:0]      slot,
	output logic [blrc_pkg::CNT_W-1:0]      entry_count,
	output logic [blrc_pkg::SIZE_W-1:0]     resident_bytes,
	output logic [blrc_pkg::CTR_W-1:0]      hit_count,
	output logic [blrc_pkg::CTR_W-1:0]      store_count
);
	import blrc_pkg::*;

	cmd_t  cmd;
	stat_t st;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	blrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	blrc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.cfg_valid      (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.func           (func),
		.key_tag        (key_tag),
		.payload_size   (payload_size),
		.now_ms         (now_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.slot           (slot),
		.entry_count    (entry_count),
		.resident_bytes (resident_bytes),
		.hit_count      (hit_count),
		.store_count    (store_count)
	);

endmodule
